// File: src/sqnz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqnz_pkg
// request codes, field widths and fixed constants of the square/noise synth
// ----------------------------------------------------------------------------
package sqnz_pkg;

    localparam int SR_W    = 20;
    localparam int FREQ_W  = 16;
    localparam int VOL_W   = 7;
    localparam int HP_W    = 19;
    localparam int BYTE_W  = 8;
    localparam int SAMP_W  = 8;
    localparam int PREV_W  = 3;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_MUTE = 2'd2;
    localparam logic [1:0] REQ_LOAD = 2'd3;

    localparam logic [SR_W-1:0]   SR_RESET   = 20'd44100;
    localparam logic [BYTE_W-1:0] NOISE_ZERO = 8'h80;
    localparam int                SAMPLE_MAX = 127;
    localparam logic [PREV_W-1:0] PREV_MAX   = 3'd7;

endpackage

`default_nettype wire

// File: src/sqnz_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqnz_div
// restoring divider, one quotient bit per cycle, for the half period
// ----------------------------------------------------------------------------
module sqnz_div
    import sqnz_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SR_W-1:0]   i_dividend,
    input  wire logic [FREQ_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [SR_W-1:0]        o_quotient
);

    localparam int CW = $clog2(SR_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [FREQ_W-1:0] r_rem;
    logic [SR_W-1:0]   r_quo;
    logic [FREQ_W-1:0] r_div;

    logic [FREQ_W:0]   rem_sh;
    logic              fits;
    logic [FREQ_W:0]   rem_nx;

    always_comb begin
        rem_sh = {r_rem, r_quo[SR_W-1]};
        fits   = rem_sh >= {1'b0, r_div};
        rem_nx = fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SR_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= rem_nx[FREQ_W-1:0];
                r_quo <= {r_quo[SR_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: src/four_voice_square_noise_synth_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_voice_square_noise_synth_core
// square and table-noise tone generator mixing VOICES voices into one sample
// ----------------------------------------------------------------------------
// Items are taken one at a time. A tick request walks the voice memory, with
// a read-modify-write state and a level state per voice (the level state uses
// the noise table read), and then registers its sample; a set-channel request
// waits on the 20-step serial divider, or skips it when it only silences the
// voice; mute-all sweeps the voice memory with a read and a write per voice; a
// noise byte load is written into the table as it is accepted. A finished
// sample waits in an output register while later set, mute and load requests
// go on; a following tick stalls only if that sample has not been taken yet.
// ----------------------------------------------------------------------------
module four_voice_square_noise_synth_core
    import sqnz_pkg::*;
#(
    parameter int VOICES      = 4,
    parameter int NOISE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // channel, playing, frequency, volume, wave_type, noise_index, noise_byte
    input  wire logic [47:0] i_s_tdata,
    // req_type
    input  wire logic [1:0]  i_s_tuser,
    // stream out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // sample
    output logic [7:0]       o_m_tdata,
    // config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PW     = (NOISE_DEPTH > 1) ? $clog2(NOISE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int ACC_W  = SAMP_W + VW + 1;
    localparam int EW     = ACC_W + 2;
    localparam int PROD_W = 2 * BYTE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_SWR  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_TUPD = 3'd5;
    localparam logic [2:0] S_TLVL = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic signed [EW-1:0] LIM_HI = EW'(SAMPLE_MAX);
    localparam logic signed [EW-1:0] LIM_LO = -EW'(SAMPLE_MAX);

    typedef struct packed {
        logic [HP_W-1:0]  hp;
        logic [HP_W-1:0]  pc;
        logic             sq;
        logic             wt;
        logic [VOL_W-1:0] vol;
        logic [PW-1:0]    pos;
    } t_voice;

    // request fields
    logic [1:0]        in_req;
    logic [1:0]        in_channel;
    logic              in_playing;
    logic [FREQ_W-1:0] in_freq;
    logic [VOL_W-1:0]  in_volume;
    logic              in_wave;
    logic [BYTE_W-1:0] in_nidx;
    logic [BYTE_W-1:0] in_nbyte;

    assign in_req     = i_s_tuser;
    assign in_channel = i_s_tdata[1:0];
    assign in_playing = i_s_tdata[2];
    assign in_freq    = i_s_tdata[18:3];
    assign in_volume  = i_s_tdata[25:19];
    assign in_wave    = i_s_tdata[26];
    assign in_nidx    = i_s_tdata[34:27];
    assign in_nbyte   = i_s_tdata[42:35];

    logic [2:0]        r_state;
    logic [1:0]        r_kind;
    logic [VW-1:0]     r_vidx;
    logic              r_last;
    logic              r_set_play;
    logic              r_set_wt;
    logic [VOL_W-1:0]  r_set_vol;
    logic [SR_W-1:0]   r_sample_rate;
    logic [PREV_W-1:0] r_prev;
    logic              r_out_vld;
    logic [SAMP_W-1:0] r_out;

    logic signed [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_lv_act;
    logic                    r_lv_wt;
    logic                    r_lv_sq;
    logic [VOL_W-1:0]        r_lv_vol;

    // voice memory
    t_voice            mem [VOICES];
    logic [VOICES-1:0] r_vld;
    t_voice            r_rd_word;
    logic              r_rd_vld;
    t_voice            cur;
    logic              mem_we;
    t_voice            mem_wdata;

    // noise table
    logic [BYTE_W-1:0] tbl [NOISE_DEPTH];
    logic [BYTE_W-1:0] r_tbl_q;
    logic              tbl_we;

    logic              accept;
    logic              ch_ok;
    logic              div_start;
    logic              div_done;
    logic [SR_W-1:0]   div_q;
    logic              cfg_we;

    // tick datapath
    logic [HP_W:0]     pc1;
    logic              wrap;
    logic [HP_W:0]     pc_new;
    logic [PW-1:0]     pos_new;
    logic              act;

    logic signed [BYTE_W-1:0] nz_d;
    logic signed [PROD_W-1:0] nz_prod;
    logic signed [PROD_W-1:0] nz_q;
    logic signed [SAMP_W-1:0] lvl;

    logic signed [EW-1:0] s_ext;
    logic signed [EW-1:0] s3;
    logic signed [EW-1:0] s_scl;
    logic signed [EW-1:0] s_clp;
    logic                 out_free;
    logic [HP_W-1:0]      hp_set;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign ch_ok      = 32'(in_channel) < VOICES;
    assign div_start  = accept && (in_req == REQ_SET) && ch_ok && in_playing
                        && (in_freq != '0);
    assign tbl_we     = accept && (in_req == REQ_LOAD) && (32'(in_nidx) < NOISE_DEPTH);
    assign cfg_we     = psel && penable && pwrite && pready && !paddr[2];
    assign out_free   = !r_out_vld || i_m_tready;
    assign cur        = r_rd_vld ? r_rd_word : '0;

    sqnz_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sample_rate),
        .i_divisor  (in_freq),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        act     = cur.vol != '0;
        pc1     = {1'b0, cur.pc} + 1'b1;
        wrap    = pc1 >= {1'b0, cur.hp};
        pc_new  = wrap ? (pc1 - {1'b0, cur.hp}) : pc1;
        pos_new = cur.pos;
        if (wrap && cur.wt) begin
            pos_new = (cur.pos == PW'(NOISE_DEPTH - 1)) ? '0 : cur.pos + 1'b1;
        end
        hp_set = (div_q[SR_W-1:1] == '0) ? HP_W'(1) : div_q[SR_W-1:1];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = cur;
        case (r_state)
            S_SWR: begin
                mem_we = 1'b1;
                if (r_set_play) begin
                    mem_wdata.hp  = hp_set;
                    mem_wdata.wt  = r_set_wt;
                    mem_wdata.vol = r_set_vol;
                    mem_wdata.pos = '0;
                end else begin
                    mem_wdata.vol = '0;
                end
            end
            S_MWR: begin
                mem_we        = 1'b1;
                mem_wdata.hp  = '0;
                mem_wdata.pc  = '0;
                mem_wdata.sq  = 1'b0;
                mem_wdata.wt  = 1'b0;
                mem_wdata.vol = '0;
            end
            S_TUPD: begin
                mem_we        = act;
                mem_wdata.pc  = pc_new[HP_W-1:0];
                mem_wdata.sq  = cur.sq ^ wrap;
                mem_wdata.pos = pos_new;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_vidx] <= mem_wdata;
        end
        r_rd_word <= mem[r_vidx];
        if (tbl_we) begin
            tbl[PW'(in_nidx)] <= in_nbyte;
        end
        r_tbl_q <= tbl[cur.pos];
    end

    // voice level
    always_comb begin
        nz_d    = $signed(r_tbl_q ^ NOISE_ZERO);
        nz_prod = PROD_W'(nz_d) * $signed(PROD_W'(r_lv_vol));
        nz_q    = (nz_prod < 0) ? ((nz_prod + PROD_W'(127)) >>> 7) : (nz_prod >>> 7);
        if (!r_lv_act) begin
            lvl = '0;
        end else if (r_lv_wt) begin
            lvl = SAMP_W'(nz_q);
        end else if (r_lv_sq) begin
            lvl = $signed({1'b0, r_lv_vol});
        end else begin
            lvl = -$signed({1'b0, r_lv_vol});
        end
    end

    // 3/4 scale when more than one voice was active in the previous sample, and clip
    always_comb begin
        s_ext = EW'(r_acc);
        s3    = s_ext + (s_ext <<< 1);
        s_scl = (r_prev > PREV_W'(1))
                ? ((s3 < 0) ? ((s3 + EW'(3)) >>> 2) : (s3 >>> 2))
                : s_ext;
        if (s_scl > LIM_HI) begin
            s_clp = LIM_HI;
        end else if (s_scl < LIM_LO) begin
            s_clp = LIM_LO;
        end else begin
            s_clp = s_scl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_vld         <= '0;
            r_rd_vld      <= 1'b0;
            r_prev        <= '0;
            r_out_vld     <= 1'b0;
            r_sample_rate <= SR_RESET;
            r_vidx        <= '0;
        end else begin
            r_rd_vld <= r_vld[r_vidx];
            if (mem_we) begin
                r_vld[r_vidx] <= 1'b1;
            end
            if (cfg_we) begin
                r_sample_rate <= pwdata[SR_W-1:0];
            end
            if (r_out_vld && i_m_tready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind     <= in_req;
                        r_set_play <= in_playing && (in_freq != '0);
                        r_set_wt   <= in_wave;
                        r_set_vol  <= in_volume;
                        r_acc      <= '0;
                        r_cnt      <= '0;
                        r_last     <= 1'b0;
                        case (in_req)
                            REQ_TICK: begin
                                r_vidx  <= '0;
                                r_state <= S_RD;
                            end
                            REQ_SET: begin
                                if (ch_ok) begin
                                    r_vidx  <= VW'(in_channel);
                                    r_state <= div_start ? S_DIV : S_RD;
                                end
                            end
                            REQ_MUTE: begin
                                r_vidx  <= '0;
                                r_state <= S_RD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SWR;
                    end
                end
                S_RD: begin
                    case (r_kind)
                        REQ_TICK: r_state <= S_TUPD;
                        REQ_SET:  r_state <= S_SWR;
                        REQ_MUTE: r_state <= S_MWR;
                        default:  r_state <= S_IDLE;
                    endcase
                end
                S_SWR: begin
                    r_state <= S_IDLE;
                end
                S_MWR: begin
                    if (r_vidx == VW'(VOICES - 1)) begin
                        r_vidx  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_vidx  <= r_vidx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_TUPD: begin
                    r_lv_act <= act;
                    r_lv_wt  <= cur.wt;
                    r_lv_sq  <= cur.sq ^ wrap;
                    r_lv_vol <= cur.vol;
                    if (act) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_last <= (r_vidx == VW'(VOICES - 1));
                    r_vidx <= (r_vidx == VW'(VOICES - 1)) ? '0 : r_vidx + 1'b1;
                    r_state <= S_TLVL;
                end
                S_TLVL: begin
                    r_acc   <= r_acc + ACC_W'(lvl);
                    r_state <= r_last ? S_OUT : S_TUPD;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out     <= s_clp[SAMP_W-1:0];
                        r_out_vld <= 1'b1;
                        r_prev    <= (32'(r_cnt) > 32'(PREV_MAX)) ? PREV_MAX
                                                                  : PREV_W'(r_cnt);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;
    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? 32'd0 : 32'(r_sample_rate);

endmodule

`default_nettype wire
